// ===== rtl/dlpe_pkg.sv =====
// shared types, constants and helpers for the dimmed rgb led pulse encoder
package dlpe_pkg;

  localparam int DURATION_BITS = 15;
  localparam int TICK_W        = 15;
  localparam int CHAN_W        = 8;
  localparam int WORD_W        = 3 * CHAN_W;
  localparam int CNT_W         = $clog2(WORD_W + 1);
  localparam int FIFO_DEPTH    = 2;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int FILL_W        = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 3;

  localparam logic [TICK_W-1:0] DUR_MASK = TICK_W'((64'd1 << DURATION_BITS) - 64'd1);

  localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ONE_LOW    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ZERO_LOW   = 3'd4;
  localparam logic [IDX_W-1:0] REG_LATCH_LOW  = 3'd5;

  localparam logic [CHAN_W-1:0] RST_BRIGHTNESS = 8'd255;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH   = TICK_W'(28) & DUR_MASK;
  localparam logic [TICK_W-1:0] RST_ONE_LOW    = TICK_W'(24) & DUR_MASK;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = TICK_W'(14) & DUR_MASK;
  localparam logic [TICK_W-1:0] RST_ZERO_LOW   = TICK_W'(34) & DUR_MASK;
  localparam logic [TICK_W-1:0] RST_LATCH_LOW  = TICK_W'(2000) & DUR_MASK;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } pix_t;

  typedef struct packed {
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] latch_low;
  } timing_t;

  // exact floor(p / 255) for p up to 255 * 255
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
    logic [2*CHAN_W:0] sum;
    sum = {1'b0, p} + (2*CHAN_W+1)'(1) + (2*CHAN_W+1)'(p[2*CHAN_W-1:CHAN_W]);
    return sum[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// ===== rtl/dlpe_front.sv =====
// front end: accepts pixels, scales each channel by brightness and packs grb
module dlpe_front import dlpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  logic              last_pixel_i,
  input  logic [CHAN_W-1:0] brightness_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output pix_t              push_data_o
);

  logic                s1_valid_q, s1_valid_d;
  logic [2*CHAN_W-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic                last_q;
  logic                accept;

  assign in_stall_o = s1_valid_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !fifo_full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_r_q <= (2*CHAN_W)'(red_i) * (2*CHAN_W)'(brightness_i);
      prod_g_q <= (2*CHAN_W)'(green_i) * (2*CHAN_W)'(brightness_i);
      prod_b_q <= (2*CHAN_W)'(blue_i) * (2*CHAN_W)'(brightness_i);
      last_q   <= last_pixel_i;
    end
  end

  assign push_data_o.word = {div255(prod_g_q), div255(prod_r_q), div255(prod_b_q)};
  assign push_data_o.last = last_q;

endmodule

// ===== rtl/dlpe_fifo.sv =====
// short pixel queue between the front end and the symbol generator
module dlpe_fifo import dlpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output pix_t head_o,
  output logic empty_o
);

  pix_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] count_q;

  assign full_o  = (count_q == FILL_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + FILL_W'(1);
        2'b01:   count_q <= count_q - FILL_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty pixel queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FILL_W'(FIFO_DEPTH)) else $error("pixel queue count overflow");

endmodule

// ===== rtl/dlpe_back.sv =====
// back end: walks the queued grb word and emits one pulse symbol per cycle while out_stall_i is low
module dlpe_back import dlpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pix_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  timing_t           timing_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              first_level_o,
  output logic [TICK_W-1:0] first_ticks_o,
  output logic [TICK_W-1:0] second_ticks_o,
  output logic              end_of_run_o
);

  logic              busy_q;
  logic [WORD_W-1:0] word_q;
  logic              last_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  logic              level_q, eor_q;
  logic [TICK_W-1:0] first_q, second_q;

  logic              advance, emit, is_data, is_final;
  logic              sym_level;
  logic [TICK_W-1:0] sym_first, sym_second;

  assign advance  = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && advance;
  assign is_data  = (cnt_q < CNT_W'(WORD_W));
  assign is_final = (cnt_q == CNT_W'(WORD_W - 1) && !last_q) || (cnt_q == CNT_W'(WORD_W));
  assign pop_o    = !empty_i && (!busy_q || (emit && is_final));

  always_comb begin
    if (is_data) begin
      sym_level  = 1'b1;
      sym_first  = word_q[WORD_W-1] ? timing_i.one_high : timing_i.zero_high;
      sym_second = word_q[WORD_W-1] ? timing_i.one_low  : timing_i.zero_low;
    end else begin
      sym_level  = 1'b0;
      sym_first  = '0;
      sym_second = timing_i.latch_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (emit) begin
        if (is_final) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= head_i.word;
      last_q <= head_i.last;
    end else if (emit) begin
      word_q <= {word_q[WORD_W-2:0], 1'b0};
    end
    if (emit) begin
      level_q  <= sym_level;
      first_q  <= sym_first;
      second_q <= sym_second;
      eor_q    <= is_final;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_level_o  = level_q;
  assign first_ticks_o  = first_q;
  assign second_ticks_o = second_q;
  assign end_of_run_o   = eor_q;

  a_latch_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !first_level_o |-> end_of_run_o && first_ticks_o == '0)
    else $error("latch symbol not marked as end of run");

  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> busy_q && cnt_q == '0) else $error("pixel load did not restart count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WORD_W)) else $error("symbol counter out of range");

endmodule

// ===== rtl/dimmed_rgb_led_pulse_encoder.sv =====
// top level: register port, front end, pixel queue and symbol generator
//
// pixels enter on in_valid_i/in_stall_o with red, green, blue and last_pixel;
// each accepted transaction yields 24 pulse symbols on out_valid_o/out_stall_i
// (green, red, blue, msb first), plus a latch symbol when last_pixel is set.
// channels are scaled by brightness as value*brightness/255, truncated.
// path: an accepted pixel passes the scaling register, the pixel queue,
// the symbol generator's word register and the output register.
// throughput: one symbol per cycle while out_stall_i is low; the symbol
// generator walks the queued word one bit each cycle and loads the next
// queued pixel without a gap.
// a two-entry pixel queue lets the front end keep accepting while symbols
// drain; when out_stall_i is held the output symbol holds and the front end
// stalls once the queue and its scaling stage are full. reset empties the
// queue and output and loads the default brightness and pulse timings; the
// user must write registers over the apb port only while idle; not enforced.
module dimmed_rgb_led_pulse_encoder import dlpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  logic              last_pixel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              first_level_o,
  output logic [TICK_W-1:0] first_ticks_o,
  output logic [TICK_W-1:0] second_ticks_o,
  output logic              end_of_run_o
);

  logic [CHAN_W-1:0] brightness_q;
  timing_t           timing_q;
  logic              cfg_wr;
  logic [IDX_W-1:0]  cfg_idx;
  logic [TICK_W-1:0] dur_wdata;

  logic fifo_full, fifo_empty, push, pop;
  pix_t push_data, head;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[ADDR_W-1:2];
  assign dur_wdata = pwdata[TICK_W-1:0] & DUR_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q       <= RST_BRIGHTNESS;
      timing_q.one_high  <= RST_ONE_HIGH;
      timing_q.one_low   <= RST_ONE_LOW;
      timing_q.zero_high <= RST_ZERO_HIGH;
      timing_q.zero_low  <= RST_ZERO_LOW;
      timing_q.latch_low <= RST_LATCH_LOW;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BRIGHTNESS: brightness_q       <= pwdata[CHAN_W-1:0];
        REG_ONE_HIGH:   timing_q.one_high  <= dur_wdata;
        REG_ONE_LOW:    timing_q.one_low   <= dur_wdata;
        REG_ZERO_HIGH:  timing_q.zero_high <= dur_wdata;
        REG_ZERO_LOW:   timing_q.zero_low  <= dur_wdata;
        REG_LATCH_LOW:  timing_q.latch_low <= dur_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BRIGHTNESS: prdata = DATA_W'(brightness_q);
      REG_ONE_HIGH:   prdata = DATA_W'(timing_q.one_high);
      REG_ONE_LOW:    prdata = DATA_W'(timing_q.one_low);
      REG_ZERO_HIGH:  prdata = DATA_W'(timing_q.zero_high);
      REG_ZERO_LOW:   prdata = DATA_W'(timing_q.zero_low);
      REG_LATCH_LOW:  prdata = DATA_W'(timing_q.latch_low);
      default:        prdata = '0;
    endcase
  end

  dlpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .brightness_i (brightness_q),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  dlpe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (fifo_empty)
  );

  dlpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (fifo_empty),
    .pop_o          (pop),
    .timing_i       (timing_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_level_o  (first_level_o),
    .first_ticks_o  (first_ticks_o),
    .second_ticks_o (second_ticks_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the dimmed rgb led pulse encoder
module testbench import dlpe_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } pixel_t;

  typedef struct packed {
    logic              level;
    logic [TICK_W-1:0] first;
    logic [TICK_W-1:0] second;
    logic              eor;
  } pulse_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CHAN_W-1:0] red_i = '0;
  logic [CHAN_W-1:0] green_i = '0;
  logic [CHAN_W-1:0] blue_i = '0;
  logic              last_pixel_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              first_level_o;
  logic [TICK_W-1:0] first_ticks_o;
  logic [TICK_W-1:0] second_ticks_o;
  logic              end_of_run_o;

  dimmed_rgb_led_pulse_encoder uut (.*);

  // local copy of the register file
  logic [CHAN_W-1:0] gain;
  logic [TICK_W-1:0] t_one_hi, t_one_lo, t_zero_hi, t_zero_lo, t_latch;

  pixel_t pixels_pending[$];
  pulse_t pulses_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int pixels_sent = 0;
  int pulses_seen = 0;
  int latches_seen = 0;
  int reg_writes = 0;
  int blocked_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [CHAN_W-1:0] scale_chan(logic [CHAN_W-1:0] v);
    logic [2*CHAN_W-1:0] prod;
    prod = v * gain;
    return CHAN_W'(prod / 16'd255);
  endfunction

  function automatic void encode_pixel(pixel_t px);
    logic [WORD_W-1:0] bits;
    pulse_t sym;
    bits = {scale_chan(px.green), scale_chan(px.red), scale_chan(px.blue)};
    for (int i = WORD_W - 1; i >= 0; i--) begin
      sym.level  = 1'b1;
      sym.first  = bits[i] ? t_one_hi : t_zero_hi;
      sym.second = bits[i] ? t_one_lo : t_zero_lo;
      sym.eor    = (i == 0) && !px.last;
      pulses_due.push_back(sym);
    end
    if (px.last) begin
      sym.level  = 1'b0;
      sym.first  = '0;
      sym.second = t_latch;
      sym.eor    = 1'b1;
      pulses_due.push_back(sym);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // pixel driver
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) blocked_cycles++;
      if (in_valid_i && !in_stall_o) begin
        encode_pixel('{red_i, green_i, blue_i, last_pixel_i});
        pixels_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixels_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          px = pixels_pending.pop_front();
          in_valid_i   <= 1'b1;
          red_i        <= px.red;
          green_i      <= px.green;
          blue_i       <= px.blue;
          last_pixel_i <= px.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long hold-off counter
  always @(posedge clk_i) begin
    if (hold_go) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ((hold_left != 0) || ($urandom_range(99) < recv_stall_pct));
  end

  // symbol monitor
  always @(posedge clk_i) begin
    pulse_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pulses_seen++;
      if (!first_level_o) latches_seen++;
      if (pulses_due.size() == 0) begin
        $display("%0t ns: unexpected symbol, expected none, got level %0d ticks %0d/%0d eor %0d",
                 $time, first_level_o, first_ticks_o, second_ticks_o, end_of_run_o);
        mismatches++;
      end else begin
        want = pulses_due.pop_front();
        check_field("first_level", want.level, first_level_o);
        check_field("first_ticks", want.first, first_ticks_o);
        check_field("second_ticks", want.second, second_ticks_o);
        check_field("end_of_run", want.eor, end_of_run_o);
      end
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    case (idx)
      REG_BRIGHTNESS: gain      = value[CHAN_W-1:0];
      REG_ONE_HIGH:   t_one_hi  = value[TICK_W-1:0] & DUR_MASK;
      REG_ONE_LOW:    t_one_lo  = value[TICK_W-1:0] & DUR_MASK;
      REG_ZERO_HIGH:  t_zero_hi = value[TICK_W-1:0] & DUR_MASK;
      REG_ZERO_LOW:   t_zero_lo = value[TICK_W-1:0] & DUR_MASK;
      REG_LATCH_LOW:  t_latch   = value[TICK_W-1:0] & DUR_MASK;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [DATA_W-1:0] oh, logic [DATA_W-1:0] ol,
                            logic [DATA_W-1:0] zh, logic [DATA_W-1:0] zl,
                            logic [DATA_W-1:0] lt);
    reg_write(REG_ONE_HIGH, oh);
    reg_write(REG_ONE_LOW, ol);
    reg_write(REG_ZERO_HIGH, zh);
    reg_write(REG_ZERO_LOW, zl);
    reg_write(REG_LATCH_LOW, lt);
  endtask

  function automatic logic [DATA_W-1:0] pick_ticks();
    case ($urandom_range(3))
      0: return '0;
      1: return 32'h7FFF;
      2: return $urandom_range(32767);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'd255;
      2: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_pixel(int r, int g, int b, bit last);
    pixels_pending.push_back('{CHAN_W'(r), CHAN_W'(g), CHAN_W'(b), last});
  endfunction

  // sampled away from the rising edge so the driver has settled
  task automatic drain();
    while (pixels_pending.size() != 0 || in_valid_i) @(negedge clk_i);
    while (pulses_due.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_strip_run(int count);
    for (int i = 0; i < count; i++) begin
      queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                  ($urandom_range(99) < 20) || (i == count - 1));
    end
  endtask

  task automatic random_phase(int count, int idle, int stall);
    reg_write(REG_BRIGHTNESS, pick_gain());
    set_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
    @(posedge clk_i);
    send_idle_pct  <= idle;
    recv_stall_pct <= stall;
    random_strip_run(count);
    drain();
  endtask

  initial begin
    gain      = RST_BRIGHTNESS;
    t_one_hi  = RST_ONE_HIGH;
    t_one_lo  = RST_ONE_LOW;
    t_zero_hi = RST_ZERO_HIGH;
    t_zero_lo = RST_ZERO_LOW;
    t_latch   = RST_LATCH_LOW;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset timings and full brightness
    queue_pixel(0, 0, 0, 0);
    queue_pixel(255, 255, 255, 0);
    queue_pixel(255, 255, 255, 1);
    queue_pixel(8'hAA, 8'h55, 8'h0F, 0);
    queue_pixel(1, 128, 254, 1);
    queue_pixel(255, 0, 0, 0);
    queue_pixel(0, 255, 0, 0);
    queue_pixel(0, 0, 255, 1);
    drain();

    // zero brightness, widest durations from oversized writes, spare address ignored
    reg_write(REG_BRIGHTNESS, 32'h0000_FF00);
    set_timing('1, '1, '1, '1, '1);
    reg_write(REG_SPARE, $urandom());
    queue_pixel(255, 255, 255, 0);
    queue_pixel(255, 255, 255, 1);
    queue_pixel(18, 200, 77, 1);
    drain();

    // minimum nonzero brightness and zero durations
    reg_write(REG_BRIGHTNESS, 32'hFFFF_FF01);
    set_timing(32'h0000_8000, 0, 32'hFFFF_0000, 0, 0);
    queue_pixel(255, 255, 255, 1);
    queue_pixel(254, 254, 254, 0);
    queue_pixel(128, 255, 1, 1);
    drain();

    reg_write(REG_BRIGHTNESS, 128);
    set_timing(1, 2, 3, 4, 5);
    queue_pixel(255, 127, 3, 0);
    queue_pixel(200, 100, 50, 1);
    drain();

    random_phase(23, 0, 0);
    random_phase(23, 72, 0);
    random_phase(23, 0, 72);
    random_phase(23, 18, 18);

    // receiver holds off while pixels keep coming
    reg_write(REG_BRIGHTNESS, pick_gain());
    set_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
    @(posedge clk_i);
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_go        <= 1'b1;
    random_strip_run(12);
    @(posedge clk_i);
    hold_go <= 1'b0;
    drain();

    repeat (20) @(posedge clk_i);
    if (pulses_due.size() != 0) begin
      $display("%0t ns: %0d symbols still outstanding", $time, pulses_due.size());
      mismatches++;
    end
    $display("covered %0d pixels, %0d symbols (%0d latch), %0d register writes",
             pixels_sent, pulses_seen, latches_seen, reg_writes);
    $display("input held back for %0d cycles, %0d mismatches", blocked_cycles, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("%0t ns: timeout", $time);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dlpe_pkg.sv
rtl/dlpe_front.sv
rtl/dlpe_fifo.sv
rtl/dlpe_back.sv
rtl/dimmed_rgb_led_pulse_encoder.sv
test/testbench.sv
